// File: design/pfa_pkg.sv
// Package for the packet frame accumulator.
// Field widths, register indexes, controller states and the command/status
// structs shared by the controller and the datapath. No dependencies.
`default_nettype none

package pfa_pkg;

  localparam int TIME_W    = 64;
  localparam int CFG_W     = 32;
  localparam int SLOT_W    = 16;
  localparam int ECHO_W    = 3;
  localparam int PC_W      = 7;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SLOT_W + CFG_W;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PPF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO     = 3'd4;

  localparam logic [CFG_W-1:0]  PERIOD_RST   = 32'd100000000;
  localparam logic [CFG_W-1:0]  INTERVAL_RST = 32'd10000;
  localparam logic [CFG_W-1:0]  MAX_GAP_RST  = 32'd18000;
  localparam logic [SLOT_W-1:0] PPF_RST      = 16'd1000;
  localparam logic [ECHO_W-1:0] ECHO_RST     = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MOD,
    ST_ALIGN,
    ST_GAP,
    ST_FILL_START,
    ST_FILL_DIV,
    ST_DECIDE,
    ST_MUL,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_in;
    logic start_mod;
    logic align;
    logic gap;
    logic start_fill;
    logic decide;
    logic mul;
    logic update;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic slot_zero;
    logic fill_need;
    logic align_skip;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// File: design/packet_frame_accumulator.sv
// Packet frame accumulator top level: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl, pfa_datapath (and pfa_div below it).
// Usage:
//   Input channel: packet_time_i / point_count_i with in_valid_i, in_stall_o.
//   Output channel: one result per packet (frame_done_o, frame_points_o,
//   frame_time_o, start_skipped_o) with out_valid_o, out_stall_i.
//   A transfer happens on a clock edge with valid high and stall low.
//   Configuration: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
// Timing:
//   One packet at a time. A packet that opens a frame runs the 64-bit period
//   modulo through the bit-serial divider, then an align step; a gap beyond
//   max_gap_ns adds a divide for the filler count. out_valid_o rises in the
//   same cycle that the result registers load. The next packet is taken the
//   cycle after the result is loaded.
// Reset:
//   Registers return to their reset values, frame state clears, no result.
// Stall:
//   A held result keeps the output register; a finished packet waits in
//   the controller until that register frees, and the input stays stalled.
`default_nettype none

module packet_frame_accumulator import pfa_pkg::*; #(
  parameter int MAX_POINTS_PER_PACKET = 96
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [TIME_W-1:0]    packet_time_i,
  input  wire logic [PC_W-1:0]      point_count_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      frame_done_o,
  output logic      [CFG_W-1:0]     frame_points_o,
  output logic      [TIME_W-1:0]    frame_time_o,
  output logic                      start_skipped_o
);

  cmd_t    cmd;
  status_t status;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pfa_datapath #(
    .MAX_POINTS_PER_PACKET(MAX_POINTS_PER_PACKET)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .packet_time_i  (packet_time_i),
    .point_count_i  (point_count_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_done_o   (frame_done_o),
    .frame_points_o (frame_points_o),
    .frame_time_o   (frame_time_o),
    .start_skipped_o(start_skipped_o)
  );

endmodule

`default_nettype wire

// File: design/pfa_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit
// divisor. Shared by the period modulo and the filler slot count.
// Depends on pfa_pkg.
`default_nettype none

module pfa_div import pfa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TIME_W-1:0] num_i,
  input  wire logic [CFG_W-1:0]  den_i,
  output logic      [TIME_W-1:0] quo_o,
  output logic      [CFG_W-1:0]  rem_o,
  output logic                   done_o
);

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(TIME_W - 1);

  logic [TIME_W-1:0]    num_q, quo_q;
  logic [CFG_W-1:0]     den_q, rem_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [CFG_W:0]       trial, trial_sub;
  logic                 ge;

  assign trial     = {rem_q, num_q[TIME_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], ge};
      num_q <= {num_q[TIME_W-2:0], 1'b0};
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/pfa_datapath.sv
// Datapath: configuration registers, frame state, alignment and gap-fill
// arithmetic, result registers. Driven by pfa_ctrl commands.
// Depends on pfa_pkg and pfa_div.
`default_nettype none

module pfa_datapath import pfa_pkg::*; #(
  parameter int MAX_POINTS_PER_PACKET = 96
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [TIME_W-1:0]    packet_time_i,
  input  wire logic [PC_W-1:0]      point_count_i,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o,
  output logic                      frame_done_o,
  output logic      [CFG_W-1:0]     frame_points_o,
  output logic      [TIME_W-1:0]    frame_time_o,
  output logic                      start_skipped_o
);

  localparam logic [10:0] MaxPts = 11'(MAX_POINTS_PER_PACKET);

  // configuration
  logic [CFG_W-1:0]  period_q, interval_q, max_gap_q;
  logic [SLOT_W-1:0] ppf_q;
  logic [ECHO_W-1:0] echo_q;

  // frame state
  logic [TIME_W-1:0] exp_q, open_q;
  logic [CFG_W-1:0]  prem_q, ptot_q;
  logic [SLOT_W-1:0] slot_q;
  logic              skip_q, pub_q;

  // per item
  logic [TIME_W-1:0] t_q, ug_q;
  logic [PC_W-1:0]   pc_q, pc_sat;
  logic              fill_need_q, skipped_q, done_q, over_q;
  logic [SLOT_W-1:0] left_q;
  logic [PROD_W-1:0] prod_q;

  // divider
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_num, div_quo;
  logic [CFG_W-1:0]  div_den, div_rem;

  logic [CFG_W-1:0]  per_eff, step, diff;
  logic              skip_hold, far, near;
  logic [TIME_W-1:0] ug, fill, fill_num;
  logic [SLOT_W-1:0] left, slot_n;

  assign pc_sat  = ({4'b0, point_count_i} > MaxPts) ? MaxPts[PC_W-1:0] : point_count_i;
  assign per_eff = (period_q == '0) ? CFG_W'(1) : period_q;
  assign step    = (interval_q == '0) ? CFG_W'(1) : interval_q;

  assign diff      = per_eff - div_rem;
  assign skip_hold = skip_q && !(prem_q > div_rem) && !(diff <= interval_q);
  assign far       = diff > (per_eff >> 2);
  assign near      = diff <= max_gap_q;

  assign ug       = t_q - exp_q;
  assign fill_num = ug_q - {32'b0, max_gap_q} + {32'b0, step - CFG_W'(1)};
  assign fill     = fill_need_q ? div_quo : '0;
  assign left     = (slot_q >= ppf_q) ? SLOT_W'(1) : ppf_q - slot_q;
  assign slot_n   = slot_q + fill[SLOT_W-1:0] + SLOT_W'(1);

  assign div_start = cmd_i.start_mod || (cmd_i.start_fill && fill_need_q);
  assign div_num   = cmd_i.start_mod ? t_q : fill_num;
  assign div_den   = cmd_i.start_mod ? per_eff : step;

  pfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .done_o (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RST;
      interval_q <= INTERVAL_RST;
      max_gap_q  <= MAX_GAP_RST;
      ppf_q      <= PPF_RST;
      echo_q     <= ECHO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PERIOD:   period_q   <= cfg_data_i;
        REG_INTERVAL: interval_q <= cfg_data_i;
        REG_MAX_GAP:  max_gap_q  <= cfg_data_i;
        REG_PPF:      ppf_q      <= cfg_data_i[SLOT_W-1:0];
        REG_ECHO:     echo_q     <= cfg_data_i[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q  <= '0;
      open_q <= '0;
      prem_q <= '0;
      ptot_q <= '0;
      slot_q <= '0;
      skip_q <= 1'b0;
      pub_q  <= 1'b0;
    end else begin
      if (cmd_i.align) begin
        if (skip_hold) begin
          prem_q <= div_rem;
        end else if (far) begin
          exp_q  <= t_q - {32'b0, div_rem};
          open_q <= t_q;
          skip_q <= 1'b0;
        end else if (near) begin
          exp_q  <= t_q;
          open_q <= t_q;
          skip_q <= 1'b0;
        end else begin
          prem_q <= div_rem;
          skip_q <= 1'b1;
        end
      end
      if (cmd_i.update) begin
        if (over_q) begin
          exp_q <= exp_q + {16'b0, prod_q};
        end else begin
          exp_q  <= t_q;
          slot_q <= slot_n;
          ptot_q <= ptot_q + {25'b0, pc_q};
        end
      end
      if (cmd_i.finish && done_q) begin
        pub_q  <= 1'b1;
        slot_q <= '0;
        ptot_q <= '0;
        skip_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t_q       <= packet_time_i;
      pc_q      <= pc_sat;
      skipped_q <= 1'b0;
      done_q    <= 1'b0;
    end
    if (cmd_i.align) begin
      skipped_q <= skip_hold || (!far && !near);
    end
    if (cmd_i.gap) begin
      ug_q        <= ug;
      fill_need_q <= pub_q && !ug[TIME_W-1] && (ug > {32'b0, max_gap_q});
    end
    if (cmd_i.decide) begin
      left_q <= left;
      over_q <= fill >= {48'b0, left};
    end
    if (cmd_i.mul) begin
      prod_q <= {32'b0, left_q} * {16'b0, step};
    end
    if (cmd_i.update) begin
      done_q <= over_q || (slot_n >= ppf_q);
    end
    if (cmd_i.finish) begin
      frame_done_o    <= done_q;
      frame_points_o  <= done_q ? ptot_q * CFG_W'(echo_q) : '0;
      frame_time_o    <= done_q ? open_q : '0;
      start_skipped_o <= skipped_q;
    end
  end

  assign status_o.slot_zero  = (slot_q == '0);
  assign status_o.fill_need  = fill_need_q;
  assign status_o.align_skip = skip_hold || (!far && !near);
  assign status_o.div_done   = div_done;

endmodule

`default_nettype wire

// File: design/pfa_ctrl.sv
// Controller: sequences one packet through modulo, alignment, gap fill and
// frame update, and owns the input stall and output valid.
// Depends on pfa_pkg.
`default_nettype none

module pfa_ctrl import pfa_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        if (status_i.slot_zero) begin
          cmd_o.start_mod = 1'b1;
          state_d         = ST_MOD;
        end else begin
          state_d = ST_GAP;
        end
      end
      ST_MOD: begin
        if (status_i.div_done) state_d = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd_o.align = 1'b1;
        state_d     = status_i.align_skip ? ST_FINISH : ST_GAP;
      end
      ST_GAP: begin
        cmd_o.gap = 1'b1;
        state_d   = ST_FILL_START;
      end
      ST_FILL_START: begin
        cmd_o.start_fill = 1'b1;
        state_d          = status_i.fill_need ? ST_FILL_DIV : ST_DECIDE;
      end
      ST_FILL_DIV: begin
        if (status_i.div_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: design/pfa_checker.sv
// Port-level checks for packet_frame_accumulator, bound to the top level.
// Depends on pfa_pkg.
`default_nettype none

module pfa_checker import pfa_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic              frame_done_o,
  input wire logic [CFG_W-1:0]  frame_points_o,
  input wire logic [TIME_W-1:0] frame_time_o,
  input wire logic              start_skipped_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while a packet is in work");

  a_done_not_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_done_o && start_skipped_o))
    else $error("frame done on a skipped packet");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_points_o == '0 && frame_time_o == '0)
    else $error("frame fields set without frame done");

endmodule

bind packet_frame_accumulator pfa_checker u_pfa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .frame_done_o   (frame_done_o),
  .frame_points_o (frame_points_o),
  .frame_time_o   (frame_time_o),
  .start_skipped_o(start_skipped_o)
);

`default_nettype wire

// File: verif/tb_top.sv
// Testbench for packet_frame_accumulator: directed and random packet streams,
// a packet-level model of frame alignment and filler slots, per-field checks.
// Depends on pfa_pkg and the packet_frame_accumulator RTL only.
`timescale 1ns / 1ps

module tb_top;
  import pfa_pkg::*;

  localparam int          PTS_CAP     = 96;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          TAIL_CYCLES = 160;
  localparam int          IDLE_PCT    = 34;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              done;
    logic [CFG_W-1:0]  points;
    logic [TIME_W-1:0] ftime;
    logic              skip;
  } frame_res_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [TIME_W-1:0]    packet_time_i = '0;
  logic [PC_W-1:0]      point_count_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic                 frame_done_o;
  logic [CFG_W-1:0]     frame_points_o;
  logic [TIME_W-1:0]    frame_time_o;
  logic                 start_skipped_o;

  packet_frame_accumulator #(
    .MAX_POINTS_PER_PACKET(PTS_CAP)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .packet_time_i  (packet_time_i),
    .point_count_i  (point_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_done_o   (frame_done_o),
    .frame_points_o (frame_points_o),
    .frame_time_o   (frame_time_o),
    .start_skipped_o(start_skipped_o)
  );

  // register mirror
  logic [CFG_W-1:0]  cfg_period   = PERIOD_RST;
  logic [CFG_W-1:0]  cfg_interval = INTERVAL_RST;
  logic [CFG_W-1:0]  cfg_max_gap  = MAX_GAP_RST;
  logic [SLOT_W-1:0] cfg_ppf      = PPF_RST;
  logic [ECHO_W-1:0] cfg_echo     = ECHO_RST;

  // frame state mirror
  logic [TIME_W-1:0] exp_time  = '0;
  logic [CFG_W-1:0]  prior_rem = '0;
  logic              skip_mode = 1'b0;
  logic [SLOT_W-1:0] slot_cnt  = '0;
  logic [CFG_W-1:0]  pts_acc   = '0;
  logic [TIME_W-1:0] open_t    = '0;
  logic              published = 1'b0;

  frame_res_t        pending_frames[$];
  logic [TIME_W-1:0] stream_t;
  int unsigned       err_cnt       = 0;
  int unsigned       n_sent        = 0;
  int unsigned       n_frames      = 0;
  int unsigned       n_skips       = 0;
  int unsigned       cycle_cnt     = 0;
  int unsigned       rx_hold_cycles = 0;
  logic              rx_quiet      = 1'b0;
  logic              tx_quiet      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_frames.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Alignment at frame open; 0 means the packet is dropped.
  function automatic logic frame_may_open(input logic [TIME_W-1:0] t);
    logic [CFG_W-1:0] per, rem, diff;
    per  = (cfg_period != 0) ? cfg_period : 32'd1;
    rem  = 32'(t % 64'(per));
    diff = per - rem;
    if (skip_mode) begin
      if (prior_rem > rem) begin
        skip_mode = 1'b0;
      end else if (diff <= cfg_interval) begin
        skip_mode = 1'b0;
      end else begin
        prior_rem = rem;
        return 1'b0;
      end
    end
    if (diff > per / 32'd4) begin
      exp_time = t - 64'(rem);
    end else if (diff <= cfg_max_gap) begin
      exp_time = t;
    end else begin
      prior_rem = rem;
      skip_mode = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic frame_res_t predict_frame(input logic [TIME_W-1:0] t,
                                               input logic [PC_W-1:0] pc_in);
    frame_res_t        r;
    logic [CFG_W-1:0]  pc;
    logic [TIME_W-1:0] fill_step, left, ug, fill;
    logic              done;
    r    = '0;
    done = 1'b0;
    pc   = (32'(pc_in) > PTS_CAP) ? 32'(PTS_CAP) : 32'(pc_in);
    fill_step = (cfg_interval != 0) ? 64'(cfg_interval) : 64'd1;
    if (slot_cnt == 0) begin
      if (!frame_may_open(t)) begin
        r.skip = 1'b1;
        return r;
      end
      open_t = t;
    end
    left = (slot_cnt >= cfg_ppf) ? 64'd1 : 64'(cfg_ppf - slot_cnt);
    ug   = t - exp_time;
    fill = '0;
    if (published && !ug[TIME_W-1] && ug > 64'(cfg_max_gap))
      fill = (ug - 64'(cfg_max_gap) + fill_step - 64'd1) / fill_step;
    if (fill >= left) begin
      // frame closes on a filler slot, this packet is lost
      exp_time = exp_time + left * fill_step;
      done     = 1'b1;
    end else begin
      exp_time = t;
      slot_cnt = 16'(64'(slot_cnt) + fill + 64'd1);
      pts_acc  = pts_acc + pc;
      if (slot_cnt >= cfg_ppf) done = 1'b1;
    end
    if (done) begin
      r.done    = 1'b1;
      r.points  = pts_acc * 32'(cfg_echo);
      r.ftime   = open_t;
      published = 1'b1;
      slot_cnt  = '0;
      pts_acc   = '0;
      skip_mode = 1'b0;
    end
    return r;
  endfunction

  task automatic send_packet(input logic [TIME_W-1:0] t, input logic [PC_W-1:0] pc);
    while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    packet_time_i <= t;
    point_count_i <= pc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_frames.push_back(predict_frame(t, pc));
    n_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_results_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PERIOD:   cfg_period   = val;
      REG_INTERVAL: cfg_interval = val;
      REG_MAX_GAP:  cfg_max_gap  = val;
      REG_PPF:      cfg_ppf      = val[SLOT_W-1:0];
      REG_ECHO:     cfg_echo     = val[ECHO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_frame_result();
    frame_res_t want;
    if (pending_frames.size() == 0) begin
      $error("result transfer with nothing outstanding");
      err_cnt++;
    end else begin
      want = pending_frames.pop_front();
      if (want.done) n_frames++;
      if (want.skip) n_skips++;
      if (frame_done_o !== want.done) begin
        $error("frame_done: expected %0d, got %0d", want.done, frame_done_o);
        err_cnt++;
      end
      if (frame_points_o !== want.points) begin
        $error("frame_points: expected %0d, got %0d", want.points, frame_points_o);
        err_cnt++;
      end
      if (frame_time_o !== want.ftime) begin
        $error("frame_time: expected %h, got %h", want.ftime, frame_time_o);
        err_cnt++;
      end
      if (start_skipped_o !== want.skip) begin
        $error("start_skipped: expected %0d, got %0d", want.skip, start_skipped_o);
        err_cnt++;
      end
    end
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_frame_result();
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles = rx_hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !rx_quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Frame-sized random settings; upper data bits of the narrow registers are noise.
  task automatic configure_random();
    logic [CFG_W-1:0]  per, intv, gap;
    logic [SLOT_W-1:0] ppf;
    logic [ECHO_W-1:0] echo;
    int unsigned       sel;
    wait_results_drained();
    sel = $urandom_range(9);
    ppf = 16'($urandom_range(1, 12));
    if (sel == 0) begin
      per = 32'hFFFF_FFFF;
      if (ppf < 2) ppf = 2;
    end else begin
      per = $urandom_range(64, 200000);
    end
    intv = per / 32'(ppf) + $urandom_range(0, 7);
    if (sel == 1) intv = $urandom_range(1, 3);
    gap = intv + $urandom_range(0, intv / 2);
    if (sel == 2) gap = 32'hFFFF_FFFF;
    echo = 3'($urandom_range(1, 4));
    write_reg(REG_PERIOD, per);
    write_reg(REG_INTERVAL, intv);
    write_reg(REG_MAX_GAP, gap);
    write_reg(REG_PPF, {16'($urandom), ppf});
    write_reg(REG_ECHO, {29'($urandom), echo});
    stream_t = {$urandom, $urandom};
  endtask

  // Mostly evenly spaced packets; gaps, rewinds, jumps and near-boundary landings mixed in.
  task automatic stream_packets(input int n);
    logic [TIME_W-1:0] fill_step, per;
    int unsigned       r;
    fill_step = (cfg_interval != 0) ? 64'(cfg_interval) : 64'd1;
    per       = (cfg_period != 0) ? 64'(cfg_period) : 64'd1;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 70)
        stream_t = stream_t + fill_step - fill_step / 16 +
                   64'($urandom_range(0, 32'(fill_step / 8)));
      else if (r < 82)
        stream_t = stream_t + fill_step * 64'($urandom_range(2, 32'(cfg_ppf) + 3));
      else if (r < 88)
        stream_t = stream_t - 64'($urandom_range(1, 32'(fill_step)));
      else if (r < 93)
        stream_t = stream_t + (64'($urandom) << $urandom_range(0, 31));
      else if (r < 98)
        stream_t = stream_t + per - stream_t % per -
                   64'($urandom_range(0, 32'(fill_step / 2)));
      else
        stream_t = {$urandom, $urandom};
      send_packet(stream_t, 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic test_reset_defaults();
    send_packet(64'd0, 7'd96);
    send_packet(64'd10000, 7'd127);
    send_packet(64'd20000, 7'd0);
    send_packet(64'd5000000, 7'd50);   // long gap before first publish: no filler
    wait_results_drained();
    write_reg(REG_PPF, 32'd2);         // below the open frame's slot count
    send_packet(64'd5010000, 7'd1);
  endtask

  task automatic test_alignment();
    wait_results_drained();
    write_reg(REG_PPF, 32'd1);
    write_reg(REG_ECHO, 32'd4);
    send_packet(64'd300000000 - 64'd5000, 7'd7);     // near boundary: open at packet
    send_packet(64'd400000000 - 64'd1000000, 7'd9);  // too close, not close enough: skip
    send_packet(64'd400000000 - 64'd500000, 7'd9);   // still skipping
    send_packet(64'd400000000 - 64'd8000, 7'd3);     // within one interval: resume
    send_packet(64'd500000000 - 64'd2000000, 7'd11);
    send_packet(64'd500000000 + 64'd100, 7'd12);     // boundary passed: resume, align down
  endtask

  task automatic test_odd_settings();
    wait_results_drained();
    write_reg(REG_ECHO, 32'd0);
    send_packet(64'd500100000, 7'd50);
    write_reg(REG_ECHO, 32'hFFFF_FFF9);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_packet(64'd600000123, 7'd60);
    write_reg(REG_PERIOD, 32'd0);
    send_packet(64'd123456789, 7'd5);
    write_reg(REG_INTERVAL, 32'd0);
    write_reg(REG_MAX_GAP, 32'd1);
    write_reg(REG_PPF, 32'd3);
    send_packet(64'd1000, 7'd10);
    send_packet(64'd1002, 7'd20);   // one filler slot, then this packet closes the frame
    send_packet(64'd2000, 7'd30);
    send_packet(64'd2100, 7'd40);   // frame ends on filler, packet dropped
    send_packet(64'd3000, 7'd1);
    send_packet(64'd2900, 7'd2);    // packet older than expected
    send_packet(64'd2901, 7'd3);
  endtask

  task automatic test_extremes();
    wait_results_drained();
    write_reg(REG_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(REG_MAX_GAP, 32'hFFFF_FFFF);
    write_reg(REG_PPF, 32'hFFFF_FFFF);
    write_reg(REG_ECHO, 32'd4);
    send_packet(64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_packet(64'h0, 7'd0);
    send_packet(64'h4000_0000_0000_0000, 7'd96);
  endtask

  task automatic test_random_streams();
    for (int k = 0; k < 8; k++) begin
      configure_random();
      stream_packets(75);
    end
  endtask

  task automatic test_output_backpressure();
    configure_random();
    rx_hold_cycles = 400;
    stream_packets(60);
  endtask

  task automatic test_sender_pause();
    configure_random();
    stream_packets(30);
    wait_results_drained();
    stream_packets(30);
  endtask

  task automatic test_full_rate();
    configure_random();
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    stream_packets(100);
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
  endtask

  task automatic test_ppf_shrink();
    for (int k = 0; k < 3; k++) begin
      configure_random();
      write_reg(REG_PPF, 32'd8);
      stream_packets(5);
      wait_results_drained();
      write_reg(REG_PPF, $urandom_range(1, 4));
      stream_packets(6);
    end
  endtask

  task automatic test_noise();
    configure_random();
    for (int k = 0; k < 40; k++)
      send_packet({$urandom, $urandom}, 7'($urandom_range(0, 127)));
  endtask

  initial begin : test_sequence
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_alignment();
    test_odd_settings();
    test_extremes();
    test_random_streams();
    test_output_backpressure();
    test_sender_pause();
    test_full_rate();
    test_ppf_shrink();
    test_noise();
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_frames.size() != 0) begin
      $error("%0d results never arrived", pending_frames.size());
      err_cnt++;
    end
    $display("Sent %0d packets: %0d frames closed, %0d dropped while aligning.",
             n_sent, n_frames, n_skips);
    $display("Settings swept from zero and minimum values to full-width registers.");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
